@@ hdl/mie_pkg.sv @@
// shared types and constants for the mips i-type execute block
// operation codes, controller states and the command/status structs
// no dependencies
package mie_pkg;

    // data memory size as address bits (byte addressed)
    localparam int MEM_ADDR_BITS = 16;

    // register file geometry
    localparam int RF_ADDR_BITS = 5;
    localparam int WORD_BITS    = 32;

    // operation codes carried on the action field
    typedef enum logic [4:0] {
        ACT_ADDI  = 5'd0,
        ACT_ADDIU = 5'd1,
        ACT_ANDI  = 5'd2,
        ACT_ORI   = 5'd3,
        ACT_XORI  = 5'd4,
        ACT_SLTI  = 5'd5,
        ACT_SLTIU = 5'd6,
        ACT_BEQ   = 5'd7,
        ACT_BNE   = 5'd8,
        ACT_LB    = 5'd9,
        ACT_LBU   = 5'd10,
        ACT_LH    = 5'd11,
        ACT_LHU   = 5'd12,
        ACT_LW    = 5'd13,
        ACT_LUI   = 5'd14,
        ACT_SB    = 5'd15,
        ACT_SH    = 5'd16,
        ACT_SW    = 5'd17
    } action_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDREG,
        ST_EXEC,
        ST_MEM_RD,
        ST_MEM_CAP,
        ST_MEM_WR,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture_in;
        logic capture_ops;
        logic exec;
        logic mem_rd;
        logic mem_cap;
        logic mem_wr;
        logic finish;
        logic clear_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_load;
        logic is_store;
        logic last_byte;
        logic out_free;
    } status_t;

endpackage

@@ hdl/mie_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
// width and depth (as address bits) set by parameters
// no dependencies
module mie_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_array [(64'd1 << ADDR_BITS)];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

@@ hdl/mie_ctrl.sv @@
// controller state machine for the i-type execute block
// sequences operand read, execute, byte-serial memory access and result hand-off
// depends on mie_pkg
module mie_ctrl
    import mie_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RDREG;
                end
            end
            ST_RDREG:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                priority if (status.is_load)
                begin
                    state_next = ST_MEM_RD;
                end
                else if (status.is_store)
                begin
                    state_next = ST_MEM_WR;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MEM_RD:
            begin
                state_next = ST_MEM_CAP;
            end
            ST_MEM_CAP:
            begin
                state_next = status.last_byte ? ST_FINISH : ST_MEM_RD;
            end
            ST_MEM_WR:
            begin
                if (status.last_byte)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.capture_in = in_valid;
            end
            ST_RDREG:
            begin
                cmd.capture_ops = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_MEM_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            ST_MEM_CAP:
            begin
                cmd.mem_cap = 1'b1;
            end
            ST_MEM_WR:
            begin
                cmd.mem_wr = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hdl/mie_datapath.sv @@
// datapath for the i-type execute block: item registers, register file,
// alu, byte-serial data memory access and the output register
// depends on mie_pkg and mie_ram
module mie_datapath
    import mie_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [4:0]            action,
    input  logic [WORD_BITS-1:0]  instruction_word,
    input  logic [WORD_BITS-1:0]  current_pc,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [WORD_BITS-1:0]  next_pc,
    output logic                  branch_taken,
    output logic                  reg_written,
    output logic [4:0]            dest_reg,
    output logic [WORD_BITS-1:0]  write_value
);

    // item registers
    logic [4:0]             action_reg;
    logic [WORD_BITS-1:0]   word_reg;
    logic [WORD_BITS-1:0]   pc4_reg;
    logic [WORD_BITS-1:0]   a_reg;
    logic [WORD_BITS-1:0]   b_reg;

    // execute results
    logic [WORD_BITS-1:0]   val_reg;
    logic                   wr_reg;
    logic                   taken_reg;
    logic [WORD_BITS-1:0]   ea_reg;
    logic [WORD_BITS-1:0]   npc_reg;
    logic [WORD_BITS-1:0]   ld_data_reg;
    logic [1:0]             byte_cnt_reg;

    // register file and memory control
    logic [(1 << RF_ADDR_BITS)-1:0] rf_valid_reg;
    logic [MEM_ADDR_BITS-1:0]       clear_cnt_reg;

    // output register
    logic                   out_valid_reg;
    logic [WORD_BITS-1:0]   out_npc_reg;
    logic                   out_taken_reg;
    logic                   out_wr_reg;
    logic [4:0]             out_dest_reg;
    logic [WORD_BITS-1:0]   out_val_reg;

    // decoded fields and combinational values
    logic [RF_ADDR_BITS-1:0] rs;
    logic [RF_ADDR_BITS-1:0] rt;
    logic [15:0]             imm;
    logic [WORD_BITS-1:0]    simm;
    logic [WORD_BITS-1:0]    zimm;
    logic [WORD_BITS-1:0]    sum;
    logic [WORD_BITS-1:0]    alu_val;
    logic                    alu_wr;
    logic                    alu_taken;
    logic [1:0]              last_idx;
    logic                    is_load;
    logic                    is_store;
    logic [WORD_BITS-1:0]    fin_val;
    logic                    wr_eff;
    logic                    out_free;

    logic [WORD_BITS-1:0]     rf_a_data;
    logic [WORD_BITS-1:0]     rf_b_data;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0]               store_byte;
    logic                     mem_wr_en;
    logic [MEM_ADDR_BITS-1:0] mem_wr_addr;
    logic [7:0]               mem_wr_data;
    logic [7:0]               mem_rd_data;

    assign rs   = word_reg[25:21];
    assign rt   = word_reg[20:16];
    assign imm  = word_reg[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'h0000, imm};
    assign sum  = a_reg + simm;

    // register file, one copy per read port, both written together
    mie_ram #(
        .WIDTH     (WORD_BITS),
        .ADDR_BITS (RF_ADDR_BITS)
    ) u_rf_a (
        .clk     (clk),
        .wr_en   (cmd.finish && wr_eff),
        .wr_addr (rt),
        .wr_data (fin_val),
        .rd_en   (cmd.capture_in),
        .rd_addr (instruction_word[25:21]),
        .rd_data (rf_a_data)
    );

    mie_ram #(
        .WIDTH     (WORD_BITS),
        .ADDR_BITS (RF_ADDR_BITS)
    ) u_rf_b (
        .clk     (clk),
        .wr_en   (cmd.finish && wr_eff),
        .wr_addr (rt),
        .wr_data (fin_val),
        .rd_en   (cmd.capture_in),
        .rd_addr (instruction_word[20:16]),
        .rd_data (rf_b_data)
    );

    // data memory, one byte per access, wraps at the top
    assign mem_addr    = ea_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(byte_cnt_reg);
    assign store_byte  = 8'(b_reg >> {byte_cnt_reg, 3'b000});
    assign mem_wr_en   = cmd.clear_step || cmd.mem_wr;
    assign mem_wr_addr = cmd.clear_step ? clear_cnt_reg : mem_addr;
    assign mem_wr_data = cmd.clear_step ? 8'h00 : store_byte;

    mie_ram #(
        .WIDTH     (8),
        .ADDR_BITS (MEM_ADDR_BITS)
    ) u_dmem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (cmd.mem_rd),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

    // alu and branch compare
    always_comb
    begin
        alu_val   = '0;
        alu_wr    = 1'b0;
        alu_taken = 1'b0;
        unique case (action_reg)
            ACT_ADDI, ACT_ADDIU:
            begin
                alu_wr  = 1'b1;
                alu_val = sum;
            end
            ACT_ANDI:
            begin
                alu_wr  = 1'b1;
                alu_val = a_reg & zimm;
            end
            ACT_ORI:
            begin
                alu_wr  = 1'b1;
                alu_val = a_reg | zimm;
            end
            ACT_XORI:
            begin
                alu_wr  = 1'b1;
                alu_val = a_reg ^ zimm;
            end
            ACT_SLTI:
            begin
                alu_wr  = 1'b1;
                alu_val = {31'h0, ($signed(a_reg) < $signed(simm))};
            end
            ACT_SLTIU:
            begin
                alu_wr  = 1'b1;
                alu_val = {31'h0, (a_reg < simm)};
            end
            ACT_BEQ:
            begin
                alu_taken = (a_reg == b_reg);
            end
            ACT_BNE:
            begin
                alu_taken = (a_reg != b_reg);
            end
            ACT_LB, ACT_LBU, ACT_LH, ACT_LHU, ACT_LW:
            begin
                alu_wr = 1'b1;
            end
            ACT_LUI:
            begin
                alu_wr  = 1'b1;
                alu_val = {imm, 16'h0000};
            end
            default:
            begin
                alu_wr = 1'b0;
            end
        endcase
    end

    // access class and last byte index
    always_comb
    begin
        is_load  = 1'b0;
        is_store = 1'b0;
        last_idx = 2'd0;
        unique case (action_reg)
            ACT_LB, ACT_LBU:
            begin
                is_load = 1'b1;
            end
            ACT_LH, ACT_LHU:
            begin
                is_load  = 1'b1;
                last_idx = 2'd1;
            end
            ACT_LW:
            begin
                is_load  = 1'b1;
                last_idx = 2'd3;
            end
            ACT_SB:
            begin
                is_store = 1'b1;
            end
            ACT_SH:
            begin
                is_store = 1'b1;
                last_idx = 2'd1;
            end
            ACT_SW:
            begin
                is_store = 1'b1;
                last_idx = 2'd3;
            end
            default:
            begin
                last_idx = 2'd0;
            end
        endcase
    end

    // final register value, loads extended here
    always_comb
    begin
        unique case (action_reg)
            ACT_LB:
            begin
                fin_val = {{24{ld_data_reg[7]}}, ld_data_reg[7:0]};
            end
            ACT_LH:
            begin
                fin_val = {{16{ld_data_reg[15]}}, ld_data_reg[15:0]};
            end
            ACT_LBU, ACT_LHU, ACT_LW:
            begin
                fin_val = ld_data_reg;
            end
            default:
            begin
                fin_val = val_reg;
            end
        endcase
    end

    assign wr_eff   = wr_reg && (rt != '0);
    assign out_free = !out_valid_reg || !out_stall;

    // status back to the controller
    always_comb
    begin
        status            = '0;
        status.clear_done = &clear_cnt_reg;
        status.is_load    = is_load;
        status.is_store   = is_store;
        status.last_byte  = (byte_cnt_reg == last_idx);
        status.out_free   = out_free;
    end

    // item and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            action_reg <= action;
            word_reg   <= instruction_word;
            pc4_reg    <= current_pc + 32'd4;
        end
        if (cmd.capture_ops)
        begin
            a_reg <= rf_valid_reg[rs] ? rf_a_data : '0;
            b_reg <= rf_valid_reg[rt] ? rf_b_data : '0;
        end
        if (cmd.exec)
        begin
            val_reg      <= alu_val;
            wr_reg       <= alu_wr;
            taken_reg    <= alu_taken;
            ea_reg       <= sum;
            npc_reg      <= pc4_reg + (alu_taken ? {simm[29:0], 2'b00} : '0);
            ld_data_reg  <= '0;
            byte_cnt_reg <= 2'd0;
        end
        if (cmd.mem_cap)
        begin
            ld_data_reg[{byte_cnt_reg, 3'b000} +: 8] <= mem_rd_data;
            byte_cnt_reg                             <= byte_cnt_reg + 2'd1;
        end
        if (cmd.mem_wr)
        begin
            byte_cnt_reg <= byte_cnt_reg + 2'd1;
        end
    end

    // register file valid bits and memory clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.finish && wr_eff)
            begin
                rf_valid_reg[rt] <= 1'b1;
            end
            if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_npc_reg   <= npc_reg;
            out_taken_reg <= taken_reg;
            out_wr_reg    <= wr_eff;
            out_dest_reg  <= wr_eff ? rt : '0;
            out_val_reg   <= wr_eff ? fin_val : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = out_npc_reg;
    assign branch_taken = out_taken_reg;
    assign reg_written  = out_wr_reg;
    assign dest_reg     = out_dest_reg;
    assign write_value  = out_val_reg;

endmodule

@@ hdl/mips_i_type_execute.sv @@
// top level of the mips i-type execute block
// joins the controller and the datapath
// depends on mie_pkg, mie_ctrl and mie_datapath
//
// usage
// - input channel: in_valid/in_stall with action, instruction_word, current_pc;
//   an item is taken at a clock edge with in_valid high and in_stall low
// - output channel: out_valid/out_stall with next_pc, branch_taken,
//   reg_written, dest_reg, write_value; one result item per input item
// - one item is worked at a time; the block is busy from acceptance until the
//   result is loaded into the output register
// - steps per item: operand read, execute and finish for alu, lui and branch
//   operations; loads add a memory read and a capture step for each byte, and
//   stores add a memory write step for each byte; this is set by the single
//   byte-wide data memory port and its registered read
// - the result is loaded into the output register in the finish step
// - reset: register file valid bits cleared at once; the data memory is then
//   cleared one byte a cycle, every byte of it, with in_stall high
// - a stalled result is held in the output register while the next item is
//   accepted and worked; the block waits before its own result only if the
//   output register is still full
module mips_i_type_execute
    import mie_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [4:0]           action,
    input  logic [WORD_BITS-1:0] instruction_word,
    input  logic [WORD_BITS-1:0] current_pc,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] next_pc,
    output logic                 branch_taken,
    output logic                 reg_written,
    output logic [4:0]           dest_reg,
    output logic [WORD_BITS-1:0] write_value
);

    cmd_t    cmd;
    status_t status;

    // sequencing
    mie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    mie_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .instruction_word (instruction_word),
        .current_pc       (current_pc),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .next_pc          (next_pc),
        .branch_taken     (branch_taken),
        .reg_written      (reg_written),
        .dest_reg         (dest_reg),
        .write_value      (write_value)
    );

endmodule

@@ hdl/mie_checker.sv @@
// port-level checks for the mips i-type execute block, bound to the top level
// watches the handshakes and the result fields over time
// depends on mips_i_type_execute
module mie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] next_pc,
    input logic        branch_taken,
    input logic        reg_written,
    input logic [4:0]  dest_reg,
    input logic [31:0] write_value
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(next_pc) && $stable(branch_taken)
            && $stable(reg_written) && $stable(dest_reg) && $stable(write_value))
        else $error("result payload changed while stalled");

    // no register write reports zero destination and value
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_written |-> dest_reg == 5'd0 && write_value == 32'd0)
        else $error("fields set without a register write");

    // a write never targets register zero
    a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_written |-> dest_reg != 5'd0)
        else $error("write reported to register zero");

    // one item at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after an item");

endmodule

bind mips_i_type_execute mie_checker u_mie_checker (.*);
